// File: rtl/xmr_pkg.sv
package xmr_pkg;

	localparam int LenW = 24;
	localparam int TickW = 12;
	localparam int DupW = 5;
	localparam int MaxRes = 4;
	localparam logic [4:0] SyncRetries = 5'd16;

	localparam logic [7:0] B_SOH = 8'h01;
	localparam logic [7:0] B_STX = 8'h02;
	localparam logic [7:0] B_EOT = 8'h04;
	localparam logic [7:0] B_ACK = 8'h06;
	localparam logic [7:0] B_NAK = 8'h15;
	localparam logic [7:0] B_CAN = 8'h18;
	localparam logic [7:0] B_C = 8'h43;

	localparam logic [1:0] REQ_BYTE = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;

	localparam logic [1:0] K_SEND = 2'd0;
	localparam logic [1:0] K_STORE = 2'd1;
	localparam logic [1:0] K_COMMIT = 2'd2;
	localparam logic [1:0] K_FINISH = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_CANCEL = 2'd1;
	localparam logic [1:0] ST_SYNC = 2'd2;
	localparam logic [1:0] ST_RETRY = 2'd3;

	localparam logic [1:0] AF_NAK = 2'd0;
	localparam logic [1:0] AF_DONE = 2'd1;
	localparam logic [1:0] AF_CANCEL = 2'd2;
	localparam logic [1:0] AF_ABORT = 2'd3;

	localparam logic [1:0] PR_NONE = 2'd0;
	localparam logic [1:0] PR_C = 2'd1;
	localparam logic [1:0] PR_NAK = 2'd2;

	localparam logic [2:0] A_MAXLEN = 3'd0;
	localparam logic [2:0] A_BYTETO = 3'd1;
	localparam logic [2:0] A_SYNCTO = 3'd2;
	localparam logic [2:0] A_FLUSH = 3'd3;
	localparam logic [2:0] A_MAXDUP = 3'd4;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_SYNC = 5'b00010,
		PH_SYNC_CAN = 5'b00100,
		PH_BLOCK = 5'b01000,
		PH_FLUSH = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] line_byte;
		logic [LenW-1:0] offset;
		logic [1:0] status;
		logic [LenW-1:0] total_length;
		logic last;
	} res_t;

	typedef struct packed {
		logic [LenW-1:0] max_length;
		logic [TickW-1:0] byte_timeout_ms;
		logic [TickW-1:0] sync_timeout_ms;
		logic [TickW-1:0] flush_quiet_ms;
		logic [DupW-1:0] max_duplicates;
	} cfg_t;

	function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/xmr_req_if.sv
interface xmr_req_if;
	logic valid;
	logic ready;
	xmr_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/xmr_res_if.sv
interface xmr_res_if;
	logic valid;
	logic ready;
	xmr_pkg::res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/xmr_regs.sv
module xmr_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output xmr_pkg::cfg_t cfg
);
	logic wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.max_length <= 24'hFFFFFF;
			cfg.byte_timeout_ms <= 12'd1000;
			cfg.sync_timeout_ms <= 12'd2000;
			cfg.flush_quiet_ms <= 12'd1500;
			cfg.max_duplicates <= 5'd25;
		end else if (wr) begin
			unique case (idx)
				xmr_pkg::A_MAXLEN: cfg.max_length <= pwdata[23:0];
				xmr_pkg::A_BYTETO: cfg.byte_timeout_ms <= pwdata[11:0];
				xmr_pkg::A_SYNCTO: cfg.sync_timeout_ms <= pwdata[11:0];
				xmr_pkg::A_FLUSH: cfg.flush_quiet_ms <= pwdata[11:0];
				xmr_pkg::A_MAXDUP: cfg.max_duplicates <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			xmr_pkg::A_MAXLEN: prdata = {8'h00, cfg.max_length};
			xmr_pkg::A_BYTETO: prdata = {20'h0, cfg.byte_timeout_ms};
			xmr_pkg::A_SYNCTO: prdata = {20'h0, cfg.sync_timeout_ms};
			xmr_pkg::A_FLUSH: prdata = {20'h0, cfg.flush_quiet_ms};
			xmr_pkg::A_MAXDUP: prdata = {27'h0, cfg.max_duplicates};
			default: prdata = '0;
		endcase
	end
endmodule

// File: rtl/xmodem_receiver.sv
// XMODEM receiver, checksum or CRC-16, 128 and 1024 byte blocks.
// req channel: one request per event: line byte, 1 ms tick, or start.
// res channel: results: send byte, store payload byte, commit, finished.
//   A request makes zero to four results; the last carries last=1.
// APB port: five config registers at byte addresses 0,4,8,12,16.
// A request is registered in stage 1, then processed by combinational logic into a
// result buffer of four entries once that buffer is free; results then show
// one per cycle while res.ready is high.
// Throughput: one request per cycle when each makes at most one result and
// the sink takes every cycle; a request is taken whenever the buffer holding
// the previous request's results is drained or drains that same cycle.
// The limit is the single result slot drained per cycle.
// Reset: phase idle, registers to defaults, buffer empty.
// Stalls: when res.ready is low results hold in the buffer and req.ready
// drops once the buffer is busy with a pending request.
module xmodem_receiver (
	input logic clk,
	input logic arst_n,
	xmr_req_if.sink req,
	xmr_res_if.source res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	xmr_pkg::cfg_t cfg;

	xmr_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	// input register stage
	logic v_s1;
	xmr_pkg::req_t r_s1;

	// result buffer
	xmr_pkg::res_t buf_q [xmr_pkg::MaxRes];
	logic [2:0] cnt_q;
	logic [1:0] rd_q;
	logic pop, buf_last;

	// transfer state
	xmr_pkg::phase_t phase_q;
	logic [1:0] probe_q, af_q, abort_q;
	logic crc_mode_q, large_q;
	logic [7:0] exp_q, bnum_q, binv_q, sum_q;
	logic [4:0] dups_q, retry_q;
	logic [11:0] tick_q;
	logic [10:0] idx_q;
	logic [15:0] crc_q, rchk_q;
	logic [23:0] clen_q;

	assign buf_last = (cnt_q != 3'd0) && ({1'b0, rd_q} == cnt_q - 3'd1);
	assign pop = res.valid && res.ready;
	// stage 1 is consumed when buffer is free or finishing now
	logic take;
	assign take = (cnt_q == 3'd0) || (pop && buf_last);
	assign req.ready = !v_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (req.ready) v_s1 <= req.valid;
	end
	always_ff @(posedge clk) if (req.ready && req.valid) r_s1 <= req.data;

	assign res.valid = cnt_q != 3'd0;
	assign res.data = buf_q[rd_q];

	// next-state and result logic
	xmr_pkg::res_t o [xmr_pkg::MaxRes];
	logic [2:0] n;
	xmr_pkg::phase_t ph_d;
	logic [1:0] probe_d, af_d, abort_d;
	logic crc_mode_d, large_d;
	logic [7:0] exp_d, bnum_d, binv_d, sum_d;
	logic [4:0] dups_d, retry_d;
	logic [11:0] tick_d, tinc, lim;
	logic [10:0] idx_d, size, idx1;
	logic [15:0] crc_d, rchk_d;
	logic [23:0] clen_d, room;
	logic [7:0] b;
	logic hdr, isnew, isdup, chk, tmo;

	always_comb begin
		b = r_s1.rx_byte;
		for (int i = 0; i < xmr_pkg::MaxRes; i++) o[i] = '0;
		n = 3'd0;
		ph_d = phase_q; probe_d = probe_q; af_d = af_q; abort_d = abort_q;
		crc_mode_d = crc_mode_q; large_d = large_q; exp_d = exp_q;
		bnum_d = bnum_q; binv_d = binv_q; sum_d = sum_q; dups_d = dups_q;
		retry_d = retry_q; tick_d = tick_q; idx_d = idx_q; crc_d = crc_q;
		rchk_d = rchk_q; clen_d = clen_q;
		size = large_q ? 11'd1024 : 11'd128;
		idx1 = idx_q + 11'd1;
		room = cfg.max_length - clen_q;
		hdr = 1'b0; isnew = 1'b0; isdup = 1'b0; chk = 1'b0;
		tinc = (tick_q < 12'd4095) ? tick_q + 12'd1 : tick_q;
		lim = cfg.flush_quiet_ms;
		if (phase_q == xmr_pkg::PH_SYNC) lim = cfg.sync_timeout_ms;
		else if (phase_q == xmr_pkg::PH_SYNC_CAN || phase_q == xmr_pkg::PH_BLOCK)
			lim = cfg.byte_timeout_ms;
		tmo = tinc >= lim;
		if (r_s1.req_type == xmr_pkg::REQ_START) begin
			probe_d = xmr_pkg::PR_C; crc_mode_d = 1'b0; exp_d = 8'd1;
			dups_d = cfg.max_duplicates; large_d = 1'b0; idx_d = '0;
			bnum_d = '0; binv_d = '0; sum_d = '0; crc_d = '0; rchk_d = '0;
			clen_d = '0; af_d = xmr_pkg::AF_NAK; abort_d = '0;
			o[0].kind = xmr_pkg::K_SEND; o[0].line_byte = xmr_pkg::B_C; n = 3'd1;
			ph_d = xmr_pkg::PH_SYNC; retry_d = '0; tick_d = '0;
		end else if (r_s1.req_type == xmr_pkg::REQ_BYTE ||
				r_s1.req_type == xmr_pkg::REQ_TICK) begin
			logic adv;
			adv = 1'b0;
			if (r_s1.req_type == xmr_pkg::REQ_TICK && phase_q != xmr_pkg::PH_IDLE)
				tick_d = tinc;
			unique case (phase_q)
				xmr_pkg::PH_SYNC: begin
					if (r_s1.req_type == xmr_pkg::REQ_TICK) adv = tmo;
					else if (b == xmr_pkg::B_SOH || b == xmr_pkg::B_STX) begin
						large_d = b == xmr_pkg::B_STX;
						if (probe_q == xmr_pkg::PR_C) crc_mode_d = 1'b1;
						probe_d = xmr_pkg::PR_NONE; idx_d = '0; sum_d = '0;
						crc_d = '0; rchk_d = '0; tick_d = '0;
						ph_d = xmr_pkg::PH_BLOCK;
					end else if (b == xmr_pkg::B_EOT) begin
						ph_d = xmr_pkg::PH_FLUSH; af_d = xmr_pkg::AF_DONE;
						abort_d = '0; tick_d = '0;
					end else if (b == xmr_pkg::B_CAN) begin
						ph_d = xmr_pkg::PH_SYNC_CAN; tick_d = '0;
					end else adv = 1'b1;
				end
				xmr_pkg::PH_SYNC_CAN: begin
					if (r_s1.req_type == xmr_pkg::REQ_TICK) adv = tmo;
					else if (b == xmr_pkg::B_CAN) begin
						ph_d = xmr_pkg::PH_FLUSH; af_d = xmr_pkg::AF_CANCEL;
						abort_d = '0; tick_d = '0;
					end else adv = 1'b1;
				end
				xmr_pkg::PH_BLOCK: begin
					if (r_s1.req_type == xmr_pkg::REQ_TICK) begin
						if (tmo) begin
							ph_d = xmr_pkg::PH_FLUSH; af_d = xmr_pkg::AF_NAK;
							abort_d = '0; tick_d = '0;
						end
					end else begin
						if (idx_q == 11'd0) bnum_d = b;
						else if (idx_q == 11'd1) binv_d = b;
						else if (idx_q < size + 11'd2) begin
							sum_d = sum_q + b;
							crc_d = xmr_pkg::crc_byte(crc_q, b);
							if (clen_q < cfg.max_length &&
									{13'd0, idx_q - 11'd2} < room) begin
								o[0].kind = xmr_pkg::K_STORE; o[0].line_byte = b;
								o[0].offset = clen_q + {13'd0, idx_q - 11'd2};
								n = 3'd1;
							end
						end else if (idx_q == size + 11'd2)
							rchk_d = crc_mode_q ? {b, 8'h00} : {8'h00, b};
						else rchk_d = rchk_q | {8'h00, b};
						idx_d = idx1; tick_d = '0;
						if (idx1 >= size + 11'd3 + {10'd0, crc_mode_q}) begin
							hdr = bnum_d == ~binv_d;
							isnew = bnum_d == exp_q;
							isdup = bnum_d == exp_q - 8'd1;
							chk = crc_mode_q ? (crc_d == rchk_d) : (sum_d == rchk_d[7:0]);
							if (!(hdr && (isnew || isdup) && chk)) begin
								ph_d = xmr_pkg::PH_FLUSH; af_d = xmr_pkg::AF_NAK;
								abort_d = '0; tick_d = '0;
							end else begin
								logic ack;
								ack = 1'b1;
								if (isnew) begin
									if (cfg.max_length > clen_q)
										clen_d = clen_q + ((room < {13'd0, size}) ?
											room : {13'd0, size});
									exp_d = exp_q + 8'd1;
									o[n[1:0]].kind = xmr_pkg::K_COMMIT;
									o[n[1:0]].total_length = clen_d;
									n = n + 3'd1;
									if (cfg.max_duplicates == '0) ack = 1'b0;
									else dups_d = cfg.max_duplicates;
								end else if (dups_q <= 5'd1) ack = 1'b0;
								else dups_d = dups_q - 5'd1;
								if (ack) begin
									o[n[1:0]].kind = xmr_pkg::K_SEND;
									o[n[1:0]].line_byte = xmr_pkg::B_ACK;
									n = n + 3'd1;
									ph_d = xmr_pkg::PH_SYNC; retry_d = '0;
								end else begin
									ph_d = xmr_pkg::PH_FLUSH; af_d = xmr_pkg::AF_ABORT;
									abort_d = xmr_pkg::ST_RETRY;
								end
								tick_d = '0;
							end
						end
					end
				end
				xmr_pkg::PH_FLUSH: begin
					if (r_s1.req_type == xmr_pkg::REQ_BYTE) tick_d = '0;
					else if (tmo) begin
						ph_d = xmr_pkg::PH_IDLE;
						unique case (af_q)
							xmr_pkg::AF_NAK: begin
								o[0].kind = xmr_pkg::K_SEND;
								o[0].line_byte = xmr_pkg::B_NAK; n = 3'd1;
								ph_d = xmr_pkg::PH_SYNC; retry_d = '0; tick_d = '0;
							end
							xmr_pkg::AF_DONE, xmr_pkg::AF_CANCEL: begin
								o[0].kind = xmr_pkg::K_SEND;
								o[0].line_byte = xmr_pkg::B_ACK;
								o[1].kind = xmr_pkg::K_FINISH;
								o[1].status = (af_q == xmr_pkg::AF_DONE) ?
									xmr_pkg::ST_DONE : xmr_pkg::ST_CANCEL;
								o[1].total_length = clen_q; n = 3'd2;
							end
							default: begin
								for (int i = 0; i < 3; i++) begin
									o[i].kind = xmr_pkg::K_SEND;
									o[i].line_byte = xmr_pkg::B_CAN;
								end
								o[3].kind = xmr_pkg::K_FINISH; o[3].status = abort_q;
								o[3].total_length = clen_q; n = 3'd4;
							end
						endcase
					end
				end
				default: ;
			endcase
			if (adv) begin
				tick_d = '0; retry_d = retry_q + 5'd1; ph_d = xmr_pkg::PH_SYNC;
				if (retry_d < xmr_pkg::SyncRetries) begin
					if (probe_q == xmr_pkg::PR_C || probe_q == xmr_pkg::PR_NAK) begin
						o[0].kind = xmr_pkg::K_SEND;
						o[0].line_byte = (probe_q == xmr_pkg::PR_C) ?
							xmr_pkg::B_C : xmr_pkg::B_NAK;
						n = 3'd1;
					end
				end else if (probe_q == xmr_pkg::PR_C) begin
					probe_d = xmr_pkg::PR_NAK; retry_d = '0;
					o[0].kind = xmr_pkg::K_SEND; o[0].line_byte = xmr_pkg::B_NAK;
					n = 3'd1;
				end else begin
					ph_d = xmr_pkg::PH_FLUSH; af_d = xmr_pkg::AF_ABORT;
					abort_d = xmr_pkg::ST_SYNC;
				end
			end
		end
		if (n != 3'd0) o[n[1:0] - 2'd1].last = 1'b1;
	end

	logic fire;
	assign fire = v_s1 && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rd_q <= '0;
			phase_q <= xmr_pkg::PH_IDLE; probe_q <= xmr_pkg::PR_C;
			af_q <= xmr_pkg::AF_NAK; abort_q <= '0; crc_mode_q <= 1'b0;
			large_q <= 1'b0; exp_q <= 8'd1; bnum_q <= '0; binv_q <= '0;
			sum_q <= '0; dups_q <= 5'd25; retry_q <= '0; tick_q <= '0;
			idx_q <= '0; crc_q <= '0; rchk_q <= '0; clen_q <= '0;
		end else begin
			if (fire) begin
				cnt_q <= n; rd_q <= '0;
				phase_q <= ph_d; probe_q <= probe_d; af_q <= af_d;
				abort_q <= abort_d; crc_mode_q <= crc_mode_d; large_q <= large_d;
				exp_q <= exp_d; bnum_q <= bnum_d; binv_q <= binv_d; sum_q <= sum_d;
				dups_q <= dups_d; retry_q <= retry_d; tick_q <= tick_d;
				idx_q <= idx_d; crc_q <= crc_d; rchk_q <= rchk_d; clen_q <= clen_d;
			end else if (pop) begin
				if (buf_last) begin
					cnt_q <= '0; rd_q <= '0;
				end else rd_q <= rd_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) for (int i = 0; i < xmr_pkg::MaxRes; i++) buf_q[i] <= o[i];
	end

`ifndef NO_ASSERTIONS
	// read pointer never passes the fill count
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 3'd0) |-> ({1'b0, rd_q} < cnt_q))
		else $error("read pointer past fill");
	// a shown result that is not final is followed by more results
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !res.data.last) |=> res.valid)
		else $error("results lost");
	// the final buffered entry carries last
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && buf_last) |-> res.data.last)
		else $error("last flag missing");
`endif
endmodule

// File: tb/xmodem_receiver_test.sv
module xmodem_receiver_test;
	import xmr_pkg::*;

	// req_type 3 is not a defined request; the block must drop it silently
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int WatchdogLimit = 20000;
	localparam int DrainCycles = 10;
	localparam int HoldOffCycles = 250;
	localparam int RandomPerPhase = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	xmr_req_if req_ch ();
	xmr_res_if res_ch ();

	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	xmodem_receiver i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// ---------------------------------------------------------------
	// Receiver model: own copy of config and transfer state
	// ---------------------------------------------------------------
	logic [23:0] cfg_max_len;
	logic [11:0] cfg_byte_to, cfg_sync_to, cfg_quiet;
	logic [4:0] cfg_max_dup;

	phase_t rx_phase;
	logic [1:0] rx_probe, rx_after, rx_abort;
	logic rx_crc_mode, rx_big;
	logic [7:0] rx_expect, rx_num, rx_inv, rx_sum;
	logic [4:0] rx_dups, rx_retry;
	int rx_ticks;
	int rx_idx;
	logic [15:0] rx_crc, rx_chk;
	logic [23:0] rx_committed;

	res_t step_res[$];      // results of the request being predicted
	res_t expected_res[$];  // results still owed by the block
	req_t pending_req[$];   // requests waiting for the driver

	int reqs_made, reqs_sent, results_seen, commits_seen, mismatches;
	int src_idle_pct, dst_stall_pct, hold_left;

	function automatic logic [15:0] crc16_next(logic [15:0] c0, logic [7:0] b);
		logic [15:0] c;
		c = c0 ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		return c;
	endfunction

	function automatic void emit(logic [1:0] k, logic [7:0] b, logic [23:0] off,
			logic [1:0] st, logic [23:0] tot);
		res_t r;
		if (step_res.size() >= MaxRes)
			return;
		r.kind = k;
		r.line_byte = b;
		r.offset = off;
		r.status = st;
		r.total_length = tot;
		r.last = 1'b0;
		step_res.push_back(r);
	endfunction

	function automatic void emit_send(logic [7:0] b);
		emit(K_SEND, b, '0, ST_DONE, '0);
	endfunction

	function automatic void clear_transfer();
		rx_phase = PH_IDLE;
		rx_probe = PR_C;
		rx_crc_mode = 1'b0;
		rx_expect = 8'd1;
		rx_dups = cfg_max_dup;
		rx_retry = '0;
		rx_ticks = 0;
		rx_big = 1'b0;
		rx_idx = 0;
		rx_num = '0;
		rx_inv = '0;
		rx_sum = '0;
		rx_crc = '0;
		rx_chk = '0;
		rx_committed = '0;
		rx_after = AF_NAK;
		rx_abort = ST_DONE;
	endfunction

	function automatic bit tick_expired(logic [11:0] limit);
		if (rx_ticks < 4095)
			rx_ticks++;
		return rx_ticks >= limit;
	endfunction

	function automatic void begin_flush(logic [1:0] after, logic [1:0] code);
		rx_phase = PH_FLUSH;
		rx_after = after;
		rx_abort = code;
		rx_ticks = 0;
	endfunction

	function automatic void enter_sync();
		rx_phase = PH_SYNC;
		rx_retry = '0;
		rx_ticks = 0;
	endfunction

	// one sync attempt used up: probe again, switch C -> NAK, or give up
	function automatic void sync_retry();
		rx_ticks = 0;
		rx_retry = rx_retry + 5'd1;
		rx_phase = PH_SYNC;
		if (rx_retry < SyncRetries) begin
			if (rx_probe == PR_C)
				emit_send(B_C);
			else if (rx_probe == PR_NAK)
				emit_send(B_NAK);
		end else if (rx_probe == PR_C) begin
			rx_probe = PR_NAK;
			rx_retry = '0;
			emit_send(B_NAK);
		end else begin
			begin_flush(AF_ABORT, ST_SYNC);
		end
	endfunction

	function automatic void flush_done();
		case (rx_after)
			AF_NAK: begin
				emit_send(B_NAK);
				enter_sync();
				return;
			end
			AF_DONE: begin
				emit_send(B_ACK);
				emit(K_FINISH, '0, '0, ST_DONE, rx_committed);
			end
			AF_CANCEL: begin
				emit_send(B_ACK);
				emit(K_FINISH, '0, '0, ST_CANCEL, rx_committed);
			end
			default: begin
				emit_send(B_CAN);
				emit_send(B_CAN);
				emit_send(B_CAN);
				emit(K_FINISH, '0, '0, rx_abort, rx_committed);
			end
		endcase
		rx_phase = PH_IDLE;
	endfunction

	function automatic void close_block(int size);
		bit hdr_ok, is_new, is_dup, chk_ok;
		int room;
		hdr_ok = rx_num == ~rx_inv;
		is_new = rx_num == rx_expect;
		is_dup = rx_num == rx_expect - 8'd1;
		chk_ok = rx_crc_mode ? (rx_crc == rx_chk) : (rx_sum == rx_chk[7:0]);
		if (!(hdr_ok && (is_new || is_dup) && chk_ok)) begin
			begin_flush(AF_NAK, ST_DONE);
			return;
		end
		if (is_new) begin
			if (cfg_max_len > rx_committed) begin
				room = cfg_max_len - rx_committed;
				rx_committed = rx_committed + 24'((room < size) ? room : size);
			end
			rx_expect = rx_expect + 8'd1;
			emit(K_COMMIT, '0, '0, ST_DONE, rx_committed);
			if (cfg_max_dup == 0) begin
				begin_flush(AF_ABORT, ST_RETRY);
				return;
			end
			rx_dups = cfg_max_dup;
		end else begin
			if (rx_dups <= 5'd1) begin
				begin_flush(AF_ABORT, ST_RETRY);
				return;
			end
			rx_dups = rx_dups - 5'd1;
		end
		emit_send(B_ACK);
		enter_sync();
	endfunction

	function automatic void block_byte(logic [7:0] b);
		int size, k;
		size = rx_big ? 1024 : 128;
		if (rx_idx == 0)
			rx_num = b;
		else if (rx_idx == 1)
			rx_inv = b;
		else if (rx_idx < size + 2) begin
			k = rx_idx - 2;
			rx_sum = rx_sum + b;
			rx_crc = crc16_next(rx_crc, b);
			// payload is stored tentatively, clipped at max_length
			if (rx_committed < cfg_max_len && k < int'(cfg_max_len - rx_committed))
				emit(K_STORE, b, rx_committed + 24'(k), ST_DONE, '0);
		end else if (rx_idx == size + 2)
			rx_chk = rx_crc_mode ? {b, 8'h00} : {8'h00, b};
		else
			rx_chk = rx_chk | {8'h00, b};
		rx_idx = (rx_idx + 1) & 11'h7FF;
		rx_ticks = 0;
		if (rx_idx >= size + 3 + rx_crc_mode)
			close_block(size);
	endfunction

	function automatic void predict(logic [1:0] rq, logic [7:0] b);
		step_res.delete();
		case (rq)
			REQ_START: begin
				clear_transfer();
				emit_send(B_C);
				enter_sync();
			end
			REQ_BYTE: begin
				case (rx_phase)
					PH_SYNC: begin
						if (b == B_SOH || b == B_STX) begin
							rx_big = b == B_STX;
							if (rx_probe == PR_C)
								rx_crc_mode = 1'b1;
							rx_probe = PR_NONE;
							rx_idx = 0;
							rx_sum = '0;
							rx_crc = '0;
							rx_chk = '0;
							rx_ticks = 0;
							rx_phase = PH_BLOCK;
						end else if (b == B_EOT)
							begin_flush(AF_DONE, ST_DONE);
						else if (b == B_CAN) begin
							rx_phase = PH_SYNC_CAN;
							rx_ticks = 0;
						end else
							sync_retry();
					end
					PH_SYNC_CAN: begin
						if (b == B_CAN)
							begin_flush(AF_CANCEL, ST_DONE);
						else
							sync_retry();
					end
					PH_BLOCK: block_byte(b);
					PH_FLUSH: rx_ticks = 0;
					default: ;
				endcase
			end
			REQ_TICK: begin
				case (rx_phase)
					PH_SYNC: if (tick_expired(cfg_sync_to)) sync_retry();
					PH_SYNC_CAN: if (tick_expired(cfg_byte_to)) sync_retry();
					PH_BLOCK: if (tick_expired(cfg_byte_to)) begin_flush(AF_NAK, ST_DONE);
					PH_FLUSH: if (tick_expired(cfg_quiet)) flush_done();
					default: ;
				endcase
			end
			default: ;
		endcase
		if (step_res.size() > 0)
			step_res[step_res.size() - 1].last = 1'b1;
		foreach (step_res[i])
			expected_res.push_back(step_res[i]);
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	task automatic put_req(logic [1:0] rq, logic [7:0] b);
		req_t r;
		// requests the block merely drops don't count toward the budget
		if (rq == REQ_START || (rq != REQ_UNUSED && rx_phase != PH_IDLE))
			reqs_made++;
		predict(rq, b);
		r.req_type = rq;
		r.rx_byte = b;
		pending_req.push_back(r);
	endtask

	task automatic put_tick();
		put_req(REQ_TICK, 8'($urandom));
	endtask

	task automatic tick_out_flush();
		for (int i = 0; i < 5000 && rx_phase == PH_FLUSH; i++)
			put_tick();
	endtask

	task automatic ensure_sync();
		if (rx_phase != PH_SYNC)
			put_req(REQ_START, 8'($urandom));
	endtask

	// well-formed 128-byte block with random content; sometimes duplicate,
	// bad header or bad check, and the odd tick inside
	task automatic send_block();
		bit crcm, bad;
		int sel;
		logic [7:0] num, b, sum;
		logic [15:0] crc;
		ensure_sync();
		put_req(REQ_BYTE, B_SOH);
		crcm = rx_crc_mode;
		sel = $urandom_range(0, 9);
		num = (sel < 7) ? rx_expect : (sel < 9) ? rx_expect - 8'd1 : 8'($urandom);
		put_req(REQ_BYTE, num);
		put_req(REQ_BYTE, ($urandom_range(0, 15) == 0) ? 8'($urandom) : ~num);
		sum = '0;
		crc = '0;
		for (int k = 0; k < 128; k++) begin
			b = 8'($urandom);
			sum = sum + b;
			crc = crc16_next(crc, b);
			put_req(REQ_BYTE, b);
			if ($urandom_range(0, 59) == 0)
				put_tick();
		end
		bad = $urandom_range(0, 11) == 0;
		if (crcm) begin
			put_req(REQ_BYTE, crc[15:8]);
			put_req(REQ_BYTE, crc[7:0] ^ {7'd0, bad});
		end else
			put_req(REQ_BYTE, sum ^ {7'd0, bad});
		tick_out_flush();
	endtask

	// short random scenarios: EOT, cancel, tick runs, random requests
	task automatic gen_random(int budget);
		int start_count, sel, n;
		start_count = reqs_made;
		while (reqs_made - start_count < budget) begin
			sel = $urandom_range(5, 9);
			if (sel == 5) begin
				ensure_sync();
				put_req(REQ_BYTE, B_EOT);
				tick_out_flush();
			end else if (sel == 6) begin
				ensure_sync();
				put_req(REQ_BYTE, B_CAN);
				put_req(REQ_BYTE, ($urandom_range(0, 2) == 0) ? 8'($urandom) : B_CAN);
				tick_out_flush();
			end else if (sel == 7) begin
				// tick runs of random length; with a short sync timeout they push through C, NAK and sync error
				n = $urandom_range(1, 40);
				for (int i = 0; i < n; i++)
					put_tick();
				tick_out_flush();
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					put_req(2'($urandom_range(0, 3)), 8'($urandom));
				tick_out_flush();
			end
		end
	endtask

	task automatic apb_write(int idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 4);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (3'(idx))
			A_MAXLEN: cfg_max_len = v[23:0];
			A_BYTETO: cfg_byte_to = v[11:0];
			A_SYNCTO: cfg_sync_to = v[11:0];
			A_FLUSH: cfg_quiet = v[11:0];
			A_MAXDUP: cfg_max_dup = v[4:0];
			default: ;
		endcase
	endtask

	task automatic write_config(logic [23:0] ml, logic [11:0] bt, logic [11:0] st,
			logic [11:0] fq, logic [4:0] md);
		apb_write(A_MAXLEN, {8'd0, ml});
		apb_write(A_BYTETO, {20'd0, bt});
		apb_write(A_SYNCTO, {20'd0, st});
		apb_write(A_FLUSH, {20'd0, fq});
		apb_write(A_MAXDUP, {27'd0, md});
	endtask

	// block idle: nothing queued, nothing owed, then a slack wait
	task automatic wait_drain();
		while (pending_req.size() != 0 || expected_res.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// short walk through sync, cancel, EOT and timeouts
	task automatic directed_part();
		put_req(REQ_BYTE, 8'hFF);       // idle: ignored
		put_tick();
		put_req(REQ_UNUSED, 8'h5A);     // undefined request type
		put_req(REQ_START, 8'h00);
		repeat (3) put_tick();          // sync timeout -> C again
		put_req(REQ_BYTE, 8'h00);       // stray byte in sync
		put_req(REQ_BYTE, B_CAN);
		put_req(REQ_BYTE, 8'h41);       // CAN then other byte
		put_req(REQ_BYTE, B_CAN);
		repeat (5) put_tick();          // lone CAN times out
		put_req(REQ_BYTE, B_CAN);
		put_req(REQ_BYTE, B_CAN);       // remote cancel
		put_tick();
		put_req(REQ_BYTE, 8'h7E);       // flush restarts quiet count
		tick_out_flush();
		put_req(REQ_START, 8'hFF);
		put_req(REQ_BYTE, B_EOT);
		tick_out_flush();
		put_req(REQ_START, 8'hAA);
		put_req(REQ_BYTE, B_STX);       // 1K block start
		put_req(REQ_BYTE, 8'h01);
		repeat (5) put_tick();          // byte timeout inside block
		tick_out_flush();
	endtask

	// ---------------------------------------------------------------
	// Request driver: offers the head of pending_req, holds until taken
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				void'(pending_req.pop_front());
				reqs_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_req.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					req_ch.valid <= 1'b1;
					req_ch.data <= pending_req[0];
				end else
					req_ch.valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result monitor: checks against the oldest owed result, drives ready
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				if (res_ch.data.kind == K_COMMIT)
					commits_seen++;
				if (expected_res.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected result %p", res_ch.data);
				end else begin
					want = expected_res.pop_front();
					if (res_ch.data.kind !== want.kind ||
							res_ch.data.line_byte !== want.line_byte ||
							res_ch.data.offset !== want.offset ||
							res_ch.data.status !== want.status ||
							res_ch.data.total_length !== want.total_length ||
							res_ch.data.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: result %0d expected %p got %p",
								results_seen, want, res_ch.data);
					end
				end
			end
			// long hold-off lets the block fill up and stall its input
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				res_ch.ready <= 1'b0;
			end else
				res_ch.ready <= $urandom_range(0, 99) >= dst_stall_pct;
		end
	end

	// watchdog: too long without any handshake on either channel
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= WatchdogLimit) begin
				$display("Test completed with failures");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		res_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		reqs_made = 0;
		reqs_sent = 0;
		results_seen = 0;
		commits_seen = 0;
		mismatches = 0;
		src_idle_pct = 0;
		dst_stall_pct = 0;
		hold_left = 0;
		cfg_max_len = 24'hFFFFFF;
		cfg_byte_to = 12'd1000;
		cfg_sync_to = 12'd2000;
		cfg_quiet = 12'd1500;
		cfg_max_dup = 5'd25;
		clear_transfer();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// phase 0: no idling, short timeouts, small length cap, pressure
		write_config(24'd200, 12'd5, 12'd3, 12'd2, 5'd3);
		directed_part();
		hold_left = HoldOffCycles;
		send_block();
		wait_drain();

		// phase 1: sender idles; zero length cap, every other register at 1
		src_idle_pct = 63;
		write_config(24'd0, 12'd1, 12'd1, 12'd1, 5'd1);
		gen_random(RandomPerPhase);
		wait_drain();

		// phase 2: receiver stalls; full length cap and duplicate budget
		src_idle_pct = 0;
		dst_stall_pct = 63;
		write_config(24'hFFFFFF, 12'd9, 12'd4, 12'd6, 5'd31);
		gen_random(RandomPerPhase);
		wait_drain();

		// phase 3: both sides idle now and then
		src_idle_pct = 26;
		dst_stall_pct = 26;
		write_config(24'd300, 12'd7, 12'd2, 12'd3, 5'd2);
		gen_random(RandomPerPhase);
		wait_drain();

		$display("Ran %0d requests through four pacing phases, checked %0d results",
			reqs_sent, results_seen);
		$display("including %0d block commits; %0d mismatches", commits_seen, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
